// ===== rtl/yrsi_pkg.sv =====
// Package for the yaw-rate segment integrator: transaction structs, state codes,
// register indexes and the fixed-point constants of the rate, filter and gain path.
// No dependencies.
`default_nettype none

package yrsi_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;
   localparam logic [CSR_INDEX_W-1:0] CSR_GYRO_OFFSET    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GYRO_SCALE     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEGMENT_LENGTH = 2'd2;

   localparam logic [23:0] GYRO_SCALE_RESET     = 24'd1023000;
   localparam logic [15:0] SEGMENT_LENGTH_RESET = 16'd10000;

   // run log
   localparam int LOG_DEPTH     = 2048;
   localparam int ENTRY_COUNT_W = 12;

   // rate path, Q8 dps
   localparam int RATE_CLAMP    = 30720;
   localparam int RATE_DEADBAND = 12;
   localparam int ROUND_Q16     = 32768;
   localparam int ROUND_Q24     = 8388608;

   // shift-add multiplier
   localparam int MUL_A_W   = 33;
   localparam int MUL_B_W   = 24;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);

   localparam logic [MUL_B_W-1:0] ALPHA_Q16 = 24'd18350;
   localparam logic [MUL_B_W-1:0] ANGLE_K   = 24'd18740;

   // gain curve, Q16
   localparam logic [18:0] GAIN_MAX_Q16 = 19'd406323;
   localparam logic [18:0] GAIN_MIN_Q16 = 19'd275251;
   localparam logic [14:0] KNEE_LOW     = 15'd2048;
   localparam logic [14:0] KNEE_HIGH    = 15'd16640;
   localparam int          KNEE_SPAN    = 14592;
   localparam logic [30:0] KNEE_ROUND   = 31'(KNEE_SPAN / 2);

   // restoring divider for the gain slope
   localparam int DIV_STEPS = 17;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam logic [30:0] KNEE_SPAN_ALIGNED = 31'(KNEE_SPAN * (1 << (DIV_STEPS - 1)));

   typedef struct packed {
      logic               run_flag;
      logic signed [15:0] gyro_raw;
      logic [12:0]        travel_step_um;
   } req_type;

   typedef struct packed {
      logic [10:0]        entry_index;
      logic [26:0]        distance_from_start_um;
      logic signed [39:0] angle_error;
   } rsp_type;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic               done;
      logic [MUL_P_W-1:0] product;
   } mul_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RATE,
      ST_FILT,
      ST_ALPHA,
      ST_GAIN,
      ST_DIV,
      ST_KGO,
      ST_KMUL,
      ST_ANGLE,
      ST_ACCUM,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/yrsi_mul.sv =====
// Unsigned shift-add multiplier, one multiplier bit per cycle, LSB first.
// Depends on yrsi_pkg for widths and the request/response structs.
`default_nettype none

module yrsi_mul (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire yrsi_pkg::mul_req_type mul_req,
   output yrsi_pkg::mul_rsp_type     mul_rsp
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [yrsi_pkg::MUL_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [yrsi_pkg::MUL_A_W-1:0]     a_ff, a_in;
   logic [yrsi_pkg::MUL_P_W-1:0]     p_ff, p_in;
   logic [yrsi_pkg::MUL_A_W:0]       sum;

   always_comb begin
      sum = {1'b0, p_ff[yrsi_pkg::MUL_P_W-1:yrsi_pkg::MUL_B_W]}
          + (p_ff[0] ? {1'b0, a_ff} : '0);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      p_in    = p_ff;
      if (mul_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = mul_req.a;
         p_in    = {{yrsi_pkg::MUL_A_W{1'b0}}, mul_req.b};
      end else if (busy_ff) begin
         // add on the low bit, shift the partial product right
         p_in   = {sum, p_ff[yrsi_pkg::MUL_B_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == yrsi_pkg::MUL_CNT_W'(yrsi_pkg::MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      p_ff <= p_in;
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = p_ff;

endmodule

`default_nettype wire

// ===== rtl/yaw_rate_segment_integrator.sv =====
// Yaw-rate segment integrator top level: tick sequencer, divider and segment log.
// Depends on yrsi_pkg and yrsi_mul.
//
//   channel | direction | handshake             | payload
//   req_    | in        | req_valid / req_stall | yrsi_pkg::req_type
//   rsp_    | out       | rsp_valid / rsp_stall | yrsi_pkg::rsp_type
//   csr_    | in        | csr_wr_en             | csr_index, csr_wr_data
//
// A tick with the run flag low leaves the sequencer idle. A running tick holds req_stall
// through four passes of the 24-step shift-add multiplier, plus the 17-step gain divider
// when the filtered rate lies on the gain slope.
// Reset is synchronous and restores the register defaults and clears all run state.
// A result waits in the output register; the next tick is taken meanwhile and only
// stalls at its own log write while that result is still pending.
`default_nettype none

module yaw_rate_segment_integrator (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire yrsi_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output yrsi_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_wr_en,
   input  wire logic [yrsi_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [yrsi_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   yrsi_pkg::state_type    state_ff, state_in;
   yrsi_pkg::mul_req_type  mul_req;
   yrsi_pkg::mul_rsp_type  mul_rsp;
   yrsi_pkg::req_type      req_ff, req_in;
   yrsi_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 prev_start_ff, prev_start_in;
   logic                                 neg_ff, neg_in;
   logic signed [15:0]                   offset_ff, offset_in;
   logic [23:0]                          scale_ff, scale_in;
   logic [15:0]                          seglen_ff, seglen_in;
   logic signed [15:0]                   rate_ff, rate_in;
   logic signed [15:0]                   filt_ff, filt_in;
   logic [18:0]                          gain_ff, gain_in;
   logic [30:0]                          rem_ff, rem_in;
   logic [30:0]                          dvs_ff, dvs_in;
   logic [15:0]                          quo_ff, quo_in;
   logic [yrsi_pkg::DIV_CNT_W-1:0]       div_cnt_ff, div_cnt_in;
   logic [25:0]                          delta_ff, delta_in;
   logic signed [39:0]                   angle_ff, angle_in;
   logic [16:0]                          seg_ff, seg_in;
   logic [26:0]                          total_ff, total_in;
   logic [yrsi_pkg::ENTRY_COUNT_W-1:0]   count_ff, count_in;

   logic                accept;
   logic signed [16:0]  raw_diff;
   logic [16:0]         raw_abs;
   logic [41:0]         rate_ext, rate_round;
   logic signed [25:0]  rate_full;
   logic signed [15:0]  rate_clamped;
   logic signed [16:0]  alpha_diff;
   logic [16:0]         alpha_abs;
   logic [32:0]         alpha_ext, alpha_round;
   logic signed [17:0]  filt_sum;
   logic [15:0]         filt_abs16;
   logic [14:0]         filt_abs;
   logic                div_ge;
   logic [49:0]         angle_ext, angle_round;
   logic [40:0]         angle_sum;
   logic [17:0]         seg_sum;
   logic [27:0]         total_sum;
   logic [26:0]         total_sat;
   logic                emit_hit;
   logic                out_free;
   logic                emit_fire;

   yrsi_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // operand preparation
   always_comb begin
      raw_diff = $signed({req_data.gyro_raw[15], req_data.gyro_raw})
               - $signed({offset_ff[15], offset_ff});
      raw_abs  = raw_diff[16] ? 17'(-raw_diff) : 17'(raw_diff);

      alpha_diff = $signed({rate_ff[15], rate_ff}) - $signed({filt_ff[15], filt_ff});
      alpha_abs  = alpha_diff[16] ? 17'(-alpha_diff) : 17'(alpha_diff);

      filt_abs16 = filt_ff[15] ? 16'(-filt_ff) : 16'(filt_ff);
      filt_abs   = filt_abs16[14:0];
   end

   // result shaping: sign, round half up, clamp, deadband; accumulator sums and the emit test
   always_comb begin
      rate_ext   = {2'b00, mul_rsp.product[39:0]};
      rate_round = (neg_ff ? (~rate_ext + 42'd1) : rate_ext) + 42'(yrsi_pkg::ROUND_Q16);
      rate_full  = $signed(rate_round[41:16]);
      if (rate_full > yrsi_pkg::RATE_CLAMP) begin
         rate_clamped = 16'(yrsi_pkg::RATE_CLAMP);
      end else if (rate_full < -yrsi_pkg::RATE_CLAMP) begin
         rate_clamped = 16'(-yrsi_pkg::RATE_CLAMP);
      end else begin
         rate_clamped = rate_full[15:0];
      end
      if (rate_clamped >= -yrsi_pkg::RATE_DEADBAND
          && rate_clamped <= yrsi_pkg::RATE_DEADBAND) begin
         rate_clamped = '0;
      end

      alpha_ext   = {2'b00, mul_rsp.product[30:0]};
      alpha_round = (neg_ff ? (~alpha_ext + 33'd1) : alpha_ext)
                  + 33'(yrsi_pkg::ROUND_Q16);
      filt_sum    = $signed({{2{filt_ff[15]}}, filt_ff})
                  + $signed({alpha_round[32], alpha_round[32:16]});

      angle_ext   = {2'b00, mul_rsp.product[47:0]};
      angle_round = (neg_ff ? (~angle_ext + 50'd1) : angle_ext)
                  + 50'(yrsi_pkg::ROUND_Q24);

      angle_sum = $signed({angle_ff[39], angle_ff})
                + $signed({{15{delta_ff[25]}}, delta_ff});
      seg_sum   = {1'b0, seg_ff} + {5'b0, req_ff.travel_step_um};
      total_sum = {1'b0, total_ff} + {11'b0, seg_ff};
      total_sat = total_sum[27] ? '1 : total_sum[26:0];

      div_ge = rem_ff >= dvs_ff;

      emit_hit  = ({1'b0, seg_ff} >= {2'b00, seglen_ff})
               && ({1'b0, count_ff} < (yrsi_pkg::ENTRY_COUNT_W + 1)'(yrsi_pkg::LOG_DEPTH));
      emit_fire = (state_ff == yrsi_pkg::ST_EMIT) && emit_hit && out_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         yrsi_pkg::ST_IDLE: begin
            if (accept && req_data.run_flag) state_in = yrsi_pkg::ST_RATE;
         end
         yrsi_pkg::ST_RATE: begin
            if (mul_rsp.done) state_in = yrsi_pkg::ST_FILT;
         end
         yrsi_pkg::ST_FILT: state_in = yrsi_pkg::ST_ALPHA;
         yrsi_pkg::ST_ALPHA: begin
            if (mul_rsp.done) state_in = yrsi_pkg::ST_GAIN;
         end
         yrsi_pkg::ST_GAIN: begin
            if (filt_abs < yrsi_pkg::KNEE_HIGH && filt_abs > yrsi_pkg::KNEE_LOW) begin
               state_in = yrsi_pkg::ST_DIV;
            end else begin
               state_in = yrsi_pkg::ST_KGO;
            end
         end
         yrsi_pkg::ST_DIV: begin
            if (div_cnt_ff == yrsi_pkg::DIV_CNT_W'(yrsi_pkg::DIV_STEPS - 1)) begin
               state_in = yrsi_pkg::ST_KGO;
            end
         end
         yrsi_pkg::ST_KGO: state_in = yrsi_pkg::ST_KMUL;
         yrsi_pkg::ST_KMUL: begin
            if (mul_rsp.done) state_in = yrsi_pkg::ST_ANGLE;
         end
         yrsi_pkg::ST_ANGLE: begin
            if (mul_rsp.done) state_in = yrsi_pkg::ST_ACCUM;
         end
         yrsi_pkg::ST_ACCUM: state_in = yrsi_pkg::ST_EMIT;
         yrsi_pkg::ST_EMIT: begin
            // hold while the previous log entry is still waiting
            if (!emit_hit || out_free) state_in = yrsi_pkg::ST_IDLE;
         end
         default: state_in = yrsi_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall     = state_ff != yrsi_pkg::ST_IDLE;
      mul_req.start = 1'b0;
      mul_req.a     = '0;
      mul_req.b     = '0;
      case (state_ff)
         yrsi_pkg::ST_IDLE: begin
            mul_req.start = accept && req_data.run_flag;
            mul_req.a     = {17'b0, raw_abs[15:0]};
            mul_req.b     = scale_ff;
         end
         yrsi_pkg::ST_FILT: begin
            mul_req.start = 1'b1;
            mul_req.a     = {17'b0, alpha_abs[15:0]};
            mul_req.b     = yrsi_pkg::ALPHA_Q16;
         end
         yrsi_pkg::ST_KGO: begin
            mul_req.start = 1'b1;
            mul_req.a     = {14'b0, gain_ff};
            mul_req.b     = yrsi_pkg::ANGLE_K;
         end
         yrsi_pkg::ST_KMUL: begin
            mul_req.start = mul_rsp.done;
            mul_req.a     = mul_rsp.product[32:0];
            mul_req.b     = {9'b0, filt_abs};
         end
         default: begin
            mul_req.start = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      req_in        = req_ff;
      prev_start_in = prev_start_ff;
      neg_in        = neg_ff;
      offset_in     = offset_ff;
      scale_in      = scale_ff;
      seglen_in     = seglen_ff;
      rate_in       = rate_ff;
      filt_in       = filt_ff;
      gain_in       = gain_ff;
      rem_in        = rem_ff;
      dvs_in        = dvs_ff;
      quo_in        = quo_ff;
      div_cnt_in    = div_cnt_ff;
      delta_in      = delta_ff;
      angle_in      = angle_ff;
      seg_in        = seg_ff;
      total_in      = total_ff;
      count_in      = count_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (csr_wr_en) begin
         case (csr_index)
            yrsi_pkg::CSR_GYRO_OFFSET:    offset_in = csr_wr_data[15:0];
            yrsi_pkg::CSR_GYRO_SCALE:     scale_in  = csr_wr_data[23:0];
            yrsi_pkg::CSR_SEGMENT_LENGTH: seglen_in = csr_wr_data[15:0];
            default: ;
         endcase
      end

      case (state_ff)
         yrsi_pkg::ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
               if (!req_data.run_flag) begin
                  prev_start_in = 1'b0;
               end else begin
                  prev_start_in = 1'b1;
                  neg_in        = raw_diff[16];
                  // rising run flag: restart the run
                  if (!prev_start_ff) begin
                     filt_in  = '0;
                     angle_in = '0;
                     seg_in   = '0;
                     total_in = '0;
                  end
               end
            end
         end
         yrsi_pkg::ST_RATE: begin
            if (mul_rsp.done) rate_in = rate_clamped;
         end
         yrsi_pkg::ST_FILT: neg_in = alpha_diff[16];
         yrsi_pkg::ST_ALPHA: begin
            if (mul_rsp.done) begin
               if (filt_sum > yrsi_pkg::RATE_CLAMP) begin
                  filt_in = 16'(yrsi_pkg::RATE_CLAMP);
               end else if (filt_sum < -yrsi_pkg::RATE_CLAMP) begin
                  filt_in = 16'(-yrsi_pkg::RATE_CLAMP);
               end else begin
                  filt_in = filt_sum[15:0];
               end
            end
         end
         yrsi_pkg::ST_GAIN: begin
            if (filt_abs >= yrsi_pkg::KNEE_HIGH) begin
               gain_in = yrsi_pkg::GAIN_MIN_Q16;
            end else if (filt_abs > yrsi_pkg::KNEE_LOW) begin
               rem_in     = {14'(filt_abs - yrsi_pkg::KNEE_LOW), 17'b0} + yrsi_pkg::KNEE_ROUND;
               dvs_in     = yrsi_pkg::KNEE_SPAN_ALIGNED;
               quo_in     = '0;
               div_cnt_in = '0;
            end else begin
               gain_in = yrsi_pkg::GAIN_MAX_Q16;
            end
         end
         yrsi_pkg::ST_DIV: begin
            // one quotient bit per cycle
            rem_in     = div_ge ? rem_ff - dvs_ff : rem_ff;
            dvs_in     = dvs_ff >> 1;
            quo_in     = {quo_ff[14:0], div_ge};
            div_cnt_in = div_cnt_ff + 1'b1;
            gain_in    = yrsi_pkg::GAIN_MAX_Q16 - {2'b00, quo_ff, div_ge};
         end
         yrsi_pkg::ST_KMUL: begin
            if (mul_rsp.done) neg_in = filt_ff[15];
         end
         yrsi_pkg::ST_ANGLE: begin
            if (mul_rsp.done) delta_in = angle_round[49:24];
         end
         yrsi_pkg::ST_ACCUM: begin
            if (angle_sum[40] != angle_sum[39]) begin
               angle_in = angle_sum[40] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
            end else begin
               angle_in = angle_sum[39:0];
            end
            seg_in = seg_sum[17] ? '1 : seg_sum[16:0];
         end
         yrsi_pkg::ST_EMIT: begin
            if (emit_fire) begin
               rsp_data_in.entry_index            = count_ff[10:0];
               rsp_data_in.distance_from_start_um = total_sat;
               rsp_data_in.angle_error            = angle_ff;
               rsp_valid_in = 1'b1;
               total_in     = total_sat;
               seg_in       = '0;
               angle_in     = '0;
               count_in     = count_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= yrsi_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         prev_start_ff <= 1'b0;
         offset_ff     <= '0;
         scale_ff      <= yrsi_pkg::GYRO_SCALE_RESET;
         seglen_ff     <= yrsi_pkg::SEGMENT_LENGTH_RESET;
         filt_ff       <= '0;
         angle_ff      <= '0;
         seg_ff        <= '0;
         total_ff      <= '0;
         count_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         prev_start_ff <= prev_start_in;
         offset_ff     <= offset_in;
         scale_ff      <= scale_in;
         seglen_ff     <= seglen_in;
         filt_ff       <= filt_in;
         angle_ff      <= angle_in;
         seg_ff        <= seg_in;
         total_ff      <= total_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      neg_ff      <= neg_in;
      rate_ff     <= rate_in;
      gain_ff     <= gain_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      quo_ff      <= quo_in;
      div_cnt_ff  <= div_cnt_in;
      delta_ff    <= delta_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_mul_done_expected: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff == yrsi_pkg::ST_RATE || state_ff == yrsi_pkg::ST_ALPHA
                        || state_ff == yrsi_pkg::ST_KMUL || state_ff == yrsi_pkg::ST_ANGLE))
      else $error("multiplier result arrived outside a waiting state");

   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == yrsi_pkg::ST_EMIT && emit_hit && rsp_valid_ff && rsp_stall)
      |=> (state_ff == yrsi_pkg::ST_EMIT))
      else $error("log entry would overwrite a pending transaction");

   a_count_with_entry: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |-> rsp_valid_ff)
      else $error("entry count moved without a new log entry");

   a_filter_bounded: assert property (@(posedge clock) disable iff (reset)
      filt_ff <= yrsi_pkg::RATE_CLAMP && filt_ff >= -yrsi_pkg::RATE_CLAMP)
      else $error("filtered rate left its clamp range");
`endif

endmodule

`default_nettype wire

// ===== verif/yrsi_checker.sv =====
// Scoreboard for the yaw-rate segment integrator: tracks register writes, predicts each
// log entry from the accepted ticks and compares it with what the block emits.
// Depends on yrsi_pkg.

module yrsi_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   input  wire logic                             req_stall,
   input  wire yrsi_pkg::req_type                req_data,
   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   input  wire yrsi_pkg::rsp_type                rsp_data,
   input  wire logic                             csr_wr_en,
   input  wire logic [yrsi_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [yrsi_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   output int                                    fail_count,
   output int                                    pending_count,
   output int                                    checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint RATE_LIMIT   = 30720;
   localparam longint DEADBAND     = 12;
   localparam longint FILTER_ALPHA = 18350;
   localparam longint GAIN_TOP     = 406323;
   localparam longint GAIN_FLOOR   = 275251;
   localparam longint GAIN_DROP    = 131072;
   localparam longint SLOPE_START  = 2048;
   localparam longint SLOPE_END    = 16640;
   localparam longint SLOPE_WIDTH  = 14592;
   localparam longint RAD_PER_MDEG = 18740;
   localparam longint ANGLE_HI     = 64'sd549755813887;
   localparam longint ANGLE_LO     = -64'sd549755813888;
   localparam logic [16:0] SEG_CEIL   = 17'h1ffff;
   localparam logic [26:0] TOTAL_CEIL = 27'h7ffffff;
   localparam int MAX_REPORTS = 10;

   // register copies
   logic signed [15:0] cfg_offset;
   logic [23:0]        cfg_scale;
   logic [15:0]        cfg_length;

   // run state
   logic               run_active;
   logic signed [15:0] filt_rate;
   logic signed [39:0] seg_angle;
   logic [16:0]        seg_dist;
   logic [26:0]        total_dist;
   logic [11:0]        entries;

   yrsi_pkg::rsp_type expected_entries[$];
   int      fails  = 0;
   int      checks = 0;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      checked_count = 0;
   end

   task automatic integrate_tick(input yrsi_pkg::req_type t);
      longint            rate;
      longint            step;
      longint            mag;
      longint            gain;
      longint            acc;
      logic [17:0]       seg_next;
      logic [27:0]       total_next;
      yrsi_pkg::rsp_type entry;
      if (!t.run_flag) begin
         run_active = 1'b0;
      end else begin
         // rising run flag restarts the segment and the distances
         if (!run_active) begin
            filt_rate  = '0;
            seg_angle  = '0;
            seg_dist   = '0;
            total_dist = '0;
         end
         run_active = 1'b1;

         rate = (longint'($signed(t.gyro_raw)) - longint'(cfg_offset)) * longint'(cfg_scale);
         rate = (rate + 64'sd32768) >>> 16;
         if (rate > RATE_LIMIT) rate = RATE_LIMIT;
         if (rate < -RATE_LIMIT) rate = -RATE_LIMIT;
         if (rate >= -DEADBAND && rate <= DEADBAND) rate = 0;

         step = ((rate - longint'(filt_rate)) * FILTER_ALPHA + 64'sd32768) >>> 16;
         acc  = longint'(filt_rate) + step;
         if (acc > RATE_LIMIT) acc = RATE_LIMIT;
         if (acc < -RATE_LIMIT) acc = -RATE_LIMIT;
         filt_rate = acc[15:0];

         mag = (acc < 0) ? -acc : acc;
         if (mag >= SLOPE_END)
            gain = GAIN_FLOOR;
         else if (mag > SLOPE_START)
            gain = GAIN_TOP - (GAIN_DROP * (mag - SLOPE_START) + SLOPE_WIDTH / 2) / SLOPE_WIDTH;
         else
            gain = GAIN_TOP;

         step = (acc * gain * RAD_PER_MDEG + 64'sd8388608) >>> 24;
         acc  = longint'(seg_angle) + step;
         if (acc > ANGLE_HI) acc = ANGLE_HI;
         if (acc < ANGLE_LO) acc = ANGLE_LO;
         seg_angle = acc[39:0];

         seg_next = seg_dist + t.travel_step_um;
         seg_dist = (seg_next > SEG_CEIL) ? SEG_CEIL : seg_next[16:0];

         // once the log is full, keep integrating but emit nothing
         if (seg_dist >= cfg_length && entries < yrsi_pkg::LOG_DEPTH) begin
            total_next = total_dist + seg_dist;
            if (total_next > TOTAL_CEIL) total_next = TOTAL_CEIL;
            entry.entry_index            = entries[10:0];
            entry.distance_from_start_um = total_next[26:0];
            entry.angle_error            = seg_angle;
            expected_entries.push_back(entry);
            total_dist = total_next[26:0];
            seg_dist   = '0;
            seg_angle  = '0;
            entries    = entries + 12'd1;
         end
      end
   endtask

   always @(posedge clock) begin
      yrsi_pkg::rsp_type entry;
      if (reset) begin
         cfg_offset = '0;
         cfg_scale  = yrsi_pkg::GYRO_SCALE_RESET;
         cfg_length = yrsi_pkg::SEGMENT_LENGTH_RESET;
         run_active = 1'b0;
         filt_rate  = '0;
         seg_angle  = '0;
         seg_dist   = '0;
         total_dist = '0;
         entries    = '0;
         expected_entries.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               yrsi_pkg::CSR_GYRO_OFFSET:    cfg_offset = csr_wr_data[15:0];
               yrsi_pkg::CSR_GYRO_SCALE:     cfg_scale  = csr_wr_data[23:0];
               yrsi_pkg::CSR_SEGMENT_LENGTH: cfg_length = csr_wr_data[15:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            integrate_tick(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_entries.size() == 0) begin
               if (fails < MAX_REPORTS)
                  $display("%0t: unexpected log entry idx %0d dist %0d angle %0d", $realtime,
                           rsp_data.entry_index, rsp_data.distance_from_start_um,
                           $signed(rsp_data.angle_error));
               fails++;
            end else begin
               entry = expected_entries.pop_front();
               checks++;
               if (rsp_data.entry_index !== entry.entry_index ||
                   rsp_data.distance_from_start_um !== entry.distance_from_start_um ||
                   rsp_data.angle_error !== entry.angle_error) begin
                  if (fails < MAX_REPORTS)
                     $display("%0t: log entry mismatch: expected idx %0d dist %0d angle %0d, got idx %0d dist %0d angle %0d",
                              $realtime, entry.entry_index, entry.distance_from_start_um,
                              $signed(entry.angle_error), rsp_data.entry_index,
                              rsp_data.distance_from_start_um, $signed(rsp_data.angle_error));
                  fails++;
               end
            end
         end
      end
      fail_count    <= fails;
      pending_count <= expected_entries.size();
      checked_count <= checks;
   end

endmodule

// ===== verif/yaw_rate_segment_integrator_tb.sv =====
// Testbench top for the yaw-rate segment integrator: clock, reset, tick stimulus,
// register writes and result back-pressure, with the verdict at the end.
// Depends on yrsi_pkg, yaw_rate_segment_integrator and yrsi_checker.

module yaw_rate_segment_integrator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES   = 200;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_TICKS    = 80;
   localparam int ZERO_LEN_TICKS = 100;

   typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_BURSTY} stall_mode_type;

   logic                                 clock       = 1'b0;
   logic                                 reset       = 1'b1;
   logic                                 req_valid   = 1'b0;
   yrsi_pkg::req_type                    req_data    = '0;
   logic                                 rsp_stall   = 1'b0;
   logic                                 csr_wr_en   = 1'b0;
   logic [yrsi_pkg::CSR_INDEX_W-1:0]     csr_index   = '0;
   logic [yrsi_pkg::CSR_DATA_W-1:0]      csr_wr_data = '0;
   logic                                 req_stall;
   logic                                 rsp_valid;
   yrsi_pkg::rsp_type                    rsp_data;

   int fail_count;
   int pending_count;
   int checked_count;

   int                 ticks_sent    = 0;
   int                 running_ticks = 0;
   int                 burst_left    = 0;
   int                 gap_max       = 0;
   int                 idle_cycles   = 0;
   logic signed [15:0] cur_offset    = '0;
   stall_mode_type     stall_mode    = STALL_NONE;
   int                 stall_mode_left = 0;
   int                 stall_run_left  = 0;

   yaw_rate_segment_integrator uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   yrsi_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result back-pressure: switch between free flow, random and long stall runs
   always @(negedge clock) begin
      if (stall_mode_left == 0) begin
         stall_mode      = stall_mode_type'($urandom_range(0, 2));
         stall_mode_left = $urandom_range(50, 400);
      end
      stall_mode_left--;
      case (stall_mode)
         STALL_NONE:   rsp_stall = 1'b0;
         STALL_RANDOM: rsp_stall = ($urandom_range(0, 2) == 0);
         default: begin
            if (stall_run_left == 0) begin
               rsp_stall      = !rsp_stall;
               stall_run_left = rsp_stall ? $urandom_range(1, 40) : $urandom_range(1, 10);
            end
            stall_run_left--;
         end
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   function automatic yrsi_pkg::req_type make_tick(input logic run, input logic [15:0] raw,
                                                   input logic [12:0] travel);
      yrsi_pkg::req_type t;
      t.run_flag       = run;
      t.gyro_raw       = raw;
      t.travel_step_um = travel;
      return t;
   endfunction

   function automatic logic [15:0] pick_raw();
      int d;
      case ($urandom_range(0, 9))
         0, 1: pick_raw = 16'($urandom);
         2:    pick_raw = ($urandom_range(0, 1) == 1) ? 16'h7fff : 16'h8000;
         3: begin
            // around the zero-rate point, into the deadband
            d = $urandom_range(0, 16);
            pick_raw = cur_offset + 16'(d - 8);
         end
         default: begin
            d = $urandom_range(0, 3000);
            pick_raw = cur_offset + 16'(d - 1500);
         end
      endcase
   endfunction

   function automatic logic [12:0] pick_travel();
      case ($urandom_range(0, 7))
         0:       pick_travel = 13'd0;
         1:       pick_travel = 13'h1fff;
         2, 3:    pick_travel = 13'($urandom);
         default: pick_travel = 13'($urandom_range(0, 2500));
      endcase
   endfunction

   task automatic send_tick(input yrsi_pkg::req_type t);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (gap_max > 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
               @(negedge clock);
               req_valid = 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid = 1'b1;
      req_data  = t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ticks_sent++;
      if (t.run_flag) running_ticks++;
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [yrsi_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [yrsi_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = val;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // registers change only with the block idle: no entry owed, last tick finished
   task automatic apply_config(input logic [15:0] offset, input logic [23:0] scale,
                               input logic [15:0] length);
      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_reg(yrsi_pkg::CSR_GYRO_OFFSET, {8'($urandom), offset});
      write_reg(yrsi_pkg::CSR_GYRO_SCALE, scale);
      write_reg(yrsi_pkg::CSR_SEGMENT_LENGTH, {8'($urandom), length});
      cur_offset = offset;
   endtask

   initial begin
      int          phase;
      int          phase_base;
      int          n;
      int          m;
      int          k;
      logic [15:0] offset_pick;
      logic [23:0] scale_pick;
      logic [15:0] length_pick;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: register defaults first
      send_tick(make_tick(1'b0, 16'h7fff, 13'h1fff));
      send_tick(make_tick(1'b1, 16'h7fff, 13'h1fff));
      send_tick(make_tick(1'b1, 16'h8000, 13'h1fff));
      send_tick(make_tick(1'b1, 16'h0000, 13'h0000));
      send_tick(make_tick(1'b1, 16'h0001, 13'd5000));
      send_tick(make_tick(1'b1, 16'hffff, 13'd5000));
      send_tick(make_tick(1'b0, 16'h1234, 13'h0aaa));
      send_tick(make_tick(1'b1, 16'h0100, 13'h1555));
      send_tick(make_tick(1'b1, 16'h0100, 13'h1555));
      // widest offset difference with full scale, one-micrometre segments
      apply_config(16'h7fff, 24'hffffff, 16'd1);
      send_tick(make_tick(1'b1, 16'h8000, 13'h0000));
      send_tick(make_tick(1'b1, 16'h7fff, 13'd1));
      // zero scale, longest segment
      apply_config(16'h8000, 24'h000000, 16'hffff);
      send_tick(make_tick(1'b0, 16'h7fff, 13'h1fff));
      send_tick(make_tick(1'b1, 16'h7fff, 13'h1fff));
      send_tick(make_tick(1'b1, 16'h8000, 13'h1fff));
      // one count lands on the deadband edge, two counts just above it
      apply_config(16'h0000, 24'd800000, 16'd2);
      send_tick(make_tick(1'b1, 16'h0001, 13'd1));
      send_tick(make_tick(1'b1, 16'hffff, 13'd0));
      send_tick(make_tick(1'b1, 16'h0002, 13'd1));

      // random: well-formed runs of ticks, with noise and broken runs mixed in
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               offset_pick = 16'h8000;
               scale_pick  = 24'd0;
               length_pick = 16'd1;
            end
            1: begin
               offset_pick = 16'h7fff;
               scale_pick  = 24'hffffff;
               length_pick = 16'hffff;
            end
            default: begin
               offset_pick = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 600)) - 16'd300;
               case ($urandom_range(0, 3))
                  0:       scale_pick = 24'($urandom);
                  1:       scale_pick = 24'($urandom_range(1, 20000));
                  default: scale_pick = 24'($urandom_range(300000, 3000000));
               endcase
               length_pick = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 65535))
                                                         : 16'($urandom_range(1, 12000));
            end
         endcase
         apply_config(offset_pick, scale_pick, length_pick);
         gap_max    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
         phase_base = running_ticks;
         while (running_ticks - phase_base < PHASE_TICKS) begin
            n = $urandom_range(3, 60);
            for (k = 0; k < n; k++)
               send_tick(make_tick(1'b1, pick_raw(), pick_travel()));
            if ($urandom_range(0, 7) == 0) begin
               m = $urandom_range(1, 4);
               for (k = 0; k < m; k++)
                  send_tick(make_tick(1'($urandom), 16'($urandom), 13'($urandom)));
            end
            m = $urandom_range(1, 3);
            for (k = 0; k < m; k++)
               send_tick(make_tick(1'b0, 16'($urandom), 13'($urandom)));
            if ($urandom_range(0, 29) == 0)
               hold_until_drained();
         end
      end

      // zero segment length: every running tick logs an entry
      apply_config(16'h0000, yrsi_pkg::GYRO_SCALE_RESET, 16'h0000);
      gap_max = 2;
      send_tick(make_tick(1'b0, 16'h0000, 13'h0000));
      for (k = 0; k < ZERO_LEN_TICKS; k++)
         send_tick(make_tick(1'b1, pick_raw(), pick_travel()));

      // long segments at full travel, then a restart that keeps the entry count
      apply_config(16'h0000, yrsi_pkg::GYRO_SCALE_RESET, 16'hffff);
      for (k = 0; k < 40; k++)
         send_tick(make_tick(1'b1, pick_raw(), 13'h1fff));
      send_tick(make_tick(1'b0, 16'h0000, 13'h0000));
      for (k = 0; k < 20; k++)
         send_tick(make_tick(1'b1, pick_raw(), pick_travel()));
      send_tick(make_tick(1'b0, 16'h0000, 13'h0000));

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Drove %0d ticks (%0d running) over a series of register settings; %0d log entries compared,",
               ticks_sent, running_ticks, checked_count);
      $display("including deadband, clamped rates, zero-length segments and restarts mid-run.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches, %0d entries never emitted", fail_count, pending_count);
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/yrsi_pkg.sv
rtl/yrsi_mul.sv
rtl/yaw_rate_segment_integrator.sv
verif/yrsi_checker.sv
verif/yaw_rate_segment_integrator_tb.sv
